// ===== sv/v3n_pkg.sv =====
// Shared types and constants for the vector normalizer.
package v3n_pkg;

  localparam int unsigned CompW   = 16;
  localparam int unsigned LenW    = 16;
  localparam int unsigned InWidth = CompW;
  localparam int unsigned OutFrac = 14;

  typedef struct packed {
    logic signed [CompW-1:0] comp_z;
    logic signed [CompW-1:0] comp_y;
    logic signed [CompW-1:0] comp_x;
  } vec_in_t;

  typedef struct packed {
    logic                    zero_vector;
    logic        [LenW-1:0]  vec_length;
    logic signed [CompW-1:0] unit_z;
    logic signed [CompW-1:0] unit_y;
    logic signed [CompW-1:0] unit_x;
  } vec_out_t;

endpackage

// ===== sv/vector3_normalize.sv =====
// Vector normalizer top level: squares, root chain, divide chain, output skid.
// Fully pipelined, one vector per cycle while the skid stage is empty. Stages:
// magnitudes, squares, (InWidth+1) root cells, (InWidth+OutFrac) divide cells
// and the output register. A zero vector gives zero components, length 0 and
// zero_vector set. The whole pipeline holds while the skid stage is full;
// in_stall_o rises only when both the output register and the skid stage
// hold a result.
module vector3_normalize (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  v3n_pkg::vec_in_t     in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output v3n_pkg::vec_out_t    out_data_o
);

  localparam int unsigned MagW  = v3n_pkg::InWidth;
  localparam int unsigned SqW   = 2 * MagW + 2;
  localparam int unsigned RootW = MagW + 1;
  localparam int unsigned NumW  = MagW + v3n_pkg::OutFrac;
  localparam int unsigned QW    = NumW;
  localparam int unsigned Lat   = 2 + RootW + NumW;

  // valid pipe; the pipeline advances whenever the output side has room
  logic             adv;
  logic [Lat-1:0]   vld_q;
  logic             skid_full_q;

  // stages 0 and 1: magnitudes and signs, then squares
  logic [MagW-1:0]  mag_q [3];
  logic [2:0]       neg_q;
  logic [2*MagW-1:0] sq_q [3];
  logic [MagW-1:0]  mag1_q [3];
  logic [2:0]       neg1_q;
  logic [SqW-1:0]   sum;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic [MagW-1:0] raw;
        raw = (i == 0) ? in_data_i.comp_x[MagW-1:0] :
              (i == 1) ? in_data_i.comp_y[MagW-1:0] : in_data_i.comp_z[MagW-1:0];
        neg_q[i] <= raw[MagW-1];
        mag_q[i] <= raw[MagW-1] ? (~raw + 1'b1) : raw;
      end
      for (int i = 0; i < 3; i++) begin
        sq_q[i]   <= mag_q[i] * mag_q[i];
        mag1_q[i] <= mag_q[i];
      end
      neg1_q <= neg_q;
    end
  end

  assign sum = {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};

  // root chain with side data carried along
  logic [SqW-1:0]   s_rem  [RootW+1];
  logic [RootW-1:0] s_root [RootW+1];
  logic [MagW-1:0]  s_mag  [RootW+1][3];
  logic [2:0]       s_neg  [RootW+1];

  assign s_rem[0]  = sum;
  assign s_root[0] = '0;
  assign s_mag[0]  = mag1_q;
  assign s_neg[0]  = neg1_q;

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    v3n_sqrt_cell #(.RemW(SqW), .RootW(RootW), .Step(k)) u_cell (
      .clk_i (clk_i), .en_i(adv), .rem_i(s_rem[k]), .root_i(s_root[k]),
      .rem_o (s_rem[k+1]), .root_o(s_root[k+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) begin
        s_mag[k+1] <= s_mag[k];
        s_neg[k+1] <= s_neg[k];
      end
    end
  end

  // divide chain
  logic [RootW-1:0] d_den [NumW+1];
  logic [NumW-1:0]  d_num [NumW+1][3];
  logic [RootW:0]   d_rem [NumW+1][3];
  logic [QW-1:0]    d_quo [NumW+1][3];
  logic [2:0]       d_neg [NumW+1];

  assign d_den[0] = s_root[RootW];
  assign d_neg[0] = s_neg[RootW];
  for (genvar i = 0; i < 3; i++) begin : g_num
    assign d_num[0][i] = {s_mag[RootW][i], {v3n_pkg::OutFrac{1'b0}}};
    assign d_rem[0][i] = '0;
    assign d_quo[0][i] = '0;
  end

  for (genvar k = 0; k < NumW; k++) begin : g_div
    v3n_div_cell #(.NumW(NumW), .DenW(RootW), .QW(QW)) u_cell (
      .clk_i(clk_i), .en_i(adv), .den_i(d_den[k]), .num_i(d_num[k]), .rem_i(d_rem[k]),
      .quo_i(d_quo[k]), .den_o(d_den[k+1]), .num_o(d_num[k+1]),
      .rem_o(d_rem[k+1]), .quo_o(d_quo[k+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) d_neg[k+1] <= d_neg[k];
    end
  end

  v3n_pkg::vec_out_t res;
  logic              zero_len;
  logic [QW-1:0]     qs [3];

  assign zero_len = (d_den[NumW] == '0);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = zero_len ? '0 : (d_neg[NumW][i] ? (~d_quo[NumW][i] + 1'b1) : d_quo[NumW][i]);
    end
    res.unit_x      = qs[0][v3n_pkg::CompW-1:0];
    res.unit_y      = qs[1][v3n_pkg::CompW-1:0];
    res.unit_z      = qs[2][v3n_pkg::CompW-1:0];
    res.vec_length  = v3n_pkg::LenW'(d_den[NumW]);
    res.zero_vector = zero_len;
  end

  // output register plus skid stage
  logic              out_vld_q;
  v3n_pkg::vec_out_t out_q;
  v3n_pkg::vec_out_t skid_q;
  logic              new_res;

  assign adv        = !skid_full_q;
  assign in_stall_o = skid_full_q;
  assign new_res    = adv && vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_vld_q   <= 1'b0;
      skid_full_q <= 1'b0;
    end else begin
      if (adv) vld_q <= {vld_q[Lat-2:0], in_valid_i};
      if (!out_vld_q || !out_stall_i) begin
        if (skid_full_q) begin
          out_vld_q   <= 1'b1;
          skid_full_q <= 1'b0;
        end else begin
          out_vld_q <= new_res;
        end
      end else if (new_res) begin
        skid_full_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || !out_stall_i) begin
      out_q <= skid_full_q ? skid_q : res;
    end else if (new_res) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/v3n_sqrt_cell.sv =====
// One restoring square-root step: resolves one root bit per cycle while en_i is high.
module v3n_sqrt_cell #(
  parameter int unsigned RemW  = 34,
  parameter int unsigned RootW = 17,
  parameter int unsigned Step  = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [RemW-1:0]  rem_i,
  input  logic [RootW-1:0] root_i,
  output logic [RemW-1:0]  rem_o,
  output logic [RootW-1:0] root_o
);

  localparam int unsigned Bt = RootW - 1 - Step;
  localparam int unsigned Sh = 2 * Bt;

  logic [RemW-1:0] trial;
  logic [RemW-1:0] rem_d;
  logic [RootW-1:0] root_d;
  logic [RemW-1:0] rem_q;
  logic [RootW-1:0] root_q;

  // trial = (2*root + 2^Bt) << Bt, root holding the bits resolved so far in place
  always_comb begin
    trial = ({{(RemW-RootW){1'b0}}, root_i} << (Bt + 1)) |
            ({{(RemW-1){1'b0}}, 1'b1} << Sh);
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = root_i | ({{(RootW-1){1'b0}}, 1'b1} << Bt);
    end else begin
      rem_d  = rem_i;
      root_d = root_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// ===== sv/v3n_div_cell.sv =====
// One restoring divide step for three numerators sharing a divisor.
module v3n_div_cell #(
  parameter int unsigned NumW = 31,
  parameter int unsigned DenW = 17,
  parameter int unsigned QW   = 16
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [DenW-1:0] den_i,
  input  logic [NumW-1:0] num_i [3],
  input  logic [DenW:0]   rem_i [3],
  input  logic [QW-1:0]   quo_i [3],
  output logic [DenW-1:0] den_o,
  output logic [NumW-1:0] num_o [3],
  output logic [DenW:0]   rem_o [3],
  output logic [QW-1:0]   quo_o [3]
);

  logic [DenW-1:0] den_q;
  logic [NumW-1:0] num_q [3];
  logic [DenW:0]   rem_q [3];
  logic [QW-1:0]   quo_q [3];
  logic [DenW:0]   shf   [3];
  logic [DenW:0]   rem_d [3];
  logic [QW-1:0]   quo_d [3];
  logic [NumW-1:0] num_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shf[i]   = {rem_i[i][DenW-1:0], num_i[i][NumW-1]};
      num_d[i] = {num_i[i][NumW-2:0], 1'b0};
      if (shf[i] >= {1'b0, den_i}) begin
        rem_d[i] = shf[i] - {1'b0, den_i};
        quo_d[i] = {quo_i[i][QW-2:0], 1'b1};
      end else begin
        rem_d[i] = shf[i];
        quo_d[i] = {quo_i[i][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q <= den_i;
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= num_d[i];
        rem_q[i] <= rem_d[i];
        quo_q[i] <= quo_d[i];
      end
    end
  end

  assign den_o = den_q;
  assign num_o = num_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the vector normalizer: directed and random vectors, scoreboard check.
`timescale 1ns / 100ps

module tb_top;

  localparam int Latency = 50;
  localparam longint CycleLimit = 400000;

  // Expected-result store with its own normalizer model.
  class norm_scoreboard;
    v3n_pkg::vec_out_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function logic [31:0] floor_root(logic [33:0] v);
      logic [33:0] rem;
      logic [33:0] root;
      logic [33:0] bitv;
      rem = v;
      root = 0;
      bitv = 34'd1 << 32;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem = rem - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root[31:0];
    endfunction

    function void note_vector(v3n_pkg::vec_in_t v);
      logic [16:0] mag[3];
      logic neg[3];
      logic signed [15:0] comps[3];
      logic [33:0] sum;
      logic [31:0] len;
      logic [31:0] q[3];
      v3n_pkg::vec_out_t r;
      comps[0] = v.comp_x;
      comps[1] = v.comp_y;
      comps[2] = v.comp_z;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = comps[i][15];
        mag[i] = neg[i] ? 17'(-$signed({comps[i][15], comps[i]})) : {1'b0, comps[i]};
        sum = sum + 34'(mag[i]) * 34'(mag[i]);
      end
      len = floor_root(sum);
      for (int i = 0; i < 3; i++) begin
        q[i] = 0;
        if (len != 0) begin
          q[i] = (32'(mag[i]) << 14) / len;
          if (neg[i]) q[i] = -q[i];
        end
      end
      r.unit_x = q[0][15:0];
      r.unit_y = q[1][15:0];
      r.unit_z = q[2][15:0];
      r.vec_length = len[15:0];
      r.zero_vector = (len == 0);
      pending.push_back(r);
    endfunction

    function void check_result(v3n_pkg::vec_out_t got);
      v3n_pkg::vec_out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.unit_x !== want.unit_x)
        $display("%0t: unit_x expected %0d actual %0d", $time, want.unit_x, got.unit_x);
      if (got.unit_y !== want.unit_y)
        $display("%0t: unit_y expected %0d actual %0d", $time, want.unit_y, got.unit_y);
      if (got.unit_z !== want.unit_z)
        $display("%0t: unit_z expected %0d actual %0d", $time, want.unit_z, got.unit_z);
      if (got.vec_length !== want.vec_length)
        $display("%0t: vec_length expected %0d actual %0d", $time, want.vec_length,
                 got.vec_length);
      if (got.zero_vector !== want.zero_vector)
        $display("%0t: zero_vector expected %0b actual %0b", $time, want.zero_vector,
                 got.zero_vector);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  v3n_pkg::vec_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  v3n_pkg::vec_out_t out_data_o;

  norm_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  longint cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  vector3_normalize i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  // Result side: stall pattern and check on each output transfer.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Leaves valid high after the transfer; drain() drops it, the next call only while it idles.
  task automatic send_vector(v3n_pkg::vec_in_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_vector(v);
    @(negedge clk_i);
  endtask

  task automatic send_xyz(int x, int y, int z);
    v3n_pkg::vec_in_t v;
    v.comp_x = x[15:0];
    v.comp_y = y[15:0];
    v.comp_z = z[15:0];
    send_vector(v);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(7)) - 16'd3;
      3: return 16'($urandom_range(600)) - 16'd300;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(int n);
    v3n_pkg::vec_in_t v;
    for (int i = 0; i < n; i++) begin
      v.comp_x = rand_comp();
      v.comp_y = rand_comp();
      v.comp_z = ($urandom_range(9) == 0) ? 16'd0 : rand_comp();
      send_vector(v);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed: zero vector, axes, extremes, mixed signs.
    send_xyz(0, 0, 0);
    send_xyz(256, 0, 0);
    send_xyz(0, -256, 0);
    send_xyz(0, 0, 1);
    send_xyz(-1, 0, 0);
    send_xyz(32767, 32767, 32767);
    send_xyz(-32768, -32768, -32768);
    send_xyz(-32768, 0, 0);
    send_xyz(32767, -32768, 32767);
    send_xyz(1, 1, 1);
    send_xyz(-1, -1, -1);
    send_xyz(3, 4, 0);
    send_xyz(-3, 0, 4);
    send_xyz(2, 3, 6);
    send_xyz(21845, -21845, 10922);
    send_xyz(0, 0, -32768);
    send_xyz(0, 0, 0);
    send_random(120);
    send_idle_pct = 63;
    send_random(120);
    send_idle_pct = 0;
    recv_stall_pct = 63;
    send_random(120);
    // Sender pauses until the pipeline is empty.
    drain();
    send_idle_pct = 33;
    recv_stall_pct = 33;
    send_random(120);
    // Long receiver hold-off so the pipeline backs up into the input.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 200;
    send_random(120);
    drain();
    repeat (Latency + 10) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
